// ----- src/sats_pkg.sv -----
// Shared types, constants and codes for the sorted attribute table search block.
package sats_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam logic [14:0] BASE_RADIUS  = 15'd16;
	localparam logic [15:0] UNIT_SCALE   = 16'd256;
	localparam logic [7:0]  RESET_COLOUR = 8'd11;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [15:0] key;
		logic [7:0]  flags;
		logic [14:0] radius;
		logic [7:0]  colour;
		logic [15:0] scale;
	} entry_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] thing_type;
		logic [7:0]  entry_flags;
		logic [14:0] entry_radius;
		logic [7:0]  entry_colour;
		logic [15:0] entry_scale;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  hit_index;
		logic [7:0]  hit_flags;
		logic [14:0] hit_radius;
		logic [7:0]  hit_colour;
		logic [15:0] hit_scale;
		logic [14:0] largest_radius;
	} result_t;

	typedef struct packed {
		logic gt;
		logic lt;
		logic eq;
	} cmp_t;

endpackage

// ----- src/sats_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module sats_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/sats_cmp.sv -----
// Shared key comparator used by the last-probed index check, the insert scan and the binary search.
module sats_cmp (
	input  logic [15:0]     key,
	input  logic [15:0]     probe,
	output sats_pkg::cmp_t  rel
);

	always_comb begin
		rel.gt = key > probe;
		rel.lt = key < probe;
		rel.eq = key == probe;
	end

endmodule

// ----- src/sats_seq.sv -----
// Sequencer that runs clear, insert and lookup over the entry RAM and the comparator.
module sats_seq #(
	parameter int TABLE_DEPTH = sats_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sats_pkg::item_t   item,
	input  logic [7:0]        missing_colour,
	output logic              res_valid,
	input  logic              res_ready,
	output sats_pkg::result_t res
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_CACHE_RD  = 8'b0000_0010,
		S_CACHE_CMP = 8'b0000_0100,
		S_BS_RD     = 8'b0000_1000,
		S_BS_CMP    = 8'b0001_0000,
		S_INS_RD    = 8'b0010_0000,
		S_INS_CMP   = 8'b0100_0000,
		S_EMIT      = 8'b1000_0000
	} state_t;

	state_t             state_q;
	sats_pkg::item_t    item_q;
	sats_pkg::result_t  res_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      last_idx_q;
	logic               last_vld_q;
	logic [14:0]        maxr_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic [AW-1:0]      mid_q;
	logic [AW-1:0]      pos_q;
	logic [5:0]         guard_q;

	logic [AW-1:0]      mid_c;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	sats_pkg::entry_t   ram_wdata;
	sats_pkg::entry_t   ram_rdata;
	sats_pkg::entry_t   new_entry;
	sats_pkg::cmp_t     rel;
	logic               full_c;

	function automatic sats_pkg::result_t miss_res(input logic [1:0] st,
			input logic [7:0] colour);
		sats_pkg::result_t r;
		r.status         = st;
		r.hit_index      = 8'd0;
		r.hit_flags      = 8'd0;
		r.hit_radius     = sats_pkg::BASE_RADIUS;
		r.hit_colour     = colour;
		r.hit_scale      = sats_pkg::UNIT_SCALE;
		r.largest_radius = '0;
		return r;
	endfunction

	function automatic sats_pkg::result_t hit_res(input sats_pkg::entry_t e,
			input logic [AW-1:0] idx);
		sats_pkg::result_t r;
		r.status         = sats_pkg::ST_OK;
		r.hit_index      = 8'(idx);
		r.hit_flags      = e.flags;
		r.hit_radius     = e.radius;
		r.hit_colour     = e.colour;
		r.hit_scale      = e.scale;
		r.largest_radius = '0;
		return r;
	endfunction

	assign mid_c  = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign full_c = count_q >= CW'(TABLE_DEPTH);

	always_comb begin
		new_entry.key    = item_q.thing_type;
		new_entry.flags  = item_q.entry_flags;
		new_entry.radius = item_q.entry_radius;
		new_entry.colour = item_q.entry_colour;
		new_entry.scale  = item_q.entry_scale;
	end

	sats_cmp u_cmp (
		.key   (item_q.thing_type),
		.probe (ram_rdata.key),
		.rel   (rel)
	);

	// Address and write control for the entry RAM.
	always_comb begin
		ram_raddr = last_idx_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = new_entry;
		case (state_q)
			S_BS_RD: begin
				ram_raddr = mid_c;
			end
			S_INS_RD: begin
				ram_raddr = pos_q - AW'(1);
				ram_we    = pos_q == '0;
			end
			S_INS_CMP: begin
				ram_we = 1'b1;
				if (rel.lt) begin
					ram_wdata = ram_rdata;
				end
			end
			default: begin
				ram_raddr = last_idx_q;
			end
		endcase
	end

	sats_ram #(
		.WIDTH ($bits(sats_pkg::entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			item_q     <= '0;
			res_q      <= '0;
			count_q    <= '0;
			last_idx_q <= '0;
			last_vld_q <= 1'b0;
			maxr_q     <= sats_pkg::BASE_RADIUS;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			pos_q      <= '0;
			guard_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= item;
						case (item.command)
							sats_pkg::CMD_CLEAR: begin
								count_q    <= '0;
								last_vld_q <= 1'b0;
								last_idx_q <= '0;
								maxr_q     <= sats_pkg::BASE_RADIUS;
								res_q      <= miss_res(sats_pkg::ST_OK, missing_colour);
								state_q    <= S_EMIT;
							end
							sats_pkg::CMD_INSERT: begin
								if (full_c) begin
									res_q   <= miss_res(sats_pkg::ST_FULL, missing_colour);
									state_q <= S_EMIT;
								end else begin
									pos_q   <= AW'(count_q);
									state_q <= S_INS_RD;
								end
							end
							default: begin
								if (last_vld_q && (CW'(last_idx_q) < count_q)) begin
									state_q <= S_CACHE_RD;
								end else if (count_q == '0) begin
									res_q   <= miss_res(sats_pkg::ST_MISS, missing_colour);
									state_q <= S_EMIT;
								end else begin
									lo_q    <= '0;
									hi_q    <= AW'(count_q - CW'(1));
									guard_q <= '0;
									state_q <= S_BS_RD;
								end
							end
						endcase
					end
				end
				S_CACHE_RD: begin
					state_q <= S_CACHE_CMP;
				end
				S_CACHE_CMP: begin
					if (rel.eq) begin
						res_q   <= hit_res(ram_rdata, last_idx_q);
						state_q <= S_EMIT;
					end else begin
						lo_q    <= '0;
						hi_q    <= AW'(count_q - CW'(1));
						guard_q <= '0;
						state_q <= S_BS_RD;
					end
				end
				S_BS_RD: begin
					if (CW'(mid_c) >= count_q) begin
						res_q   <= miss_res(sats_pkg::ST_MISS, missing_colour);
						state_q <= S_EMIT;
					end else begin
						mid_q      <= mid_c;
						last_idx_q <= mid_c;
						last_vld_q <= 1'b1;
						state_q    <= S_BS_CMP;
					end
				end
				S_BS_CMP: begin
					guard_q <= guard_q + 6'd1;
					if (rel.eq) begin
						res_q   <= hit_res(ram_rdata, mid_q);
						state_q <= S_EMIT;
					end else if ((lo_q >= hi_q) || (guard_q == '1) ||
						(rel.lt && (mid_q == '0))) begin
						res_q   <= miss_res(sats_pkg::ST_MISS, missing_colour);
						state_q <= S_EMIT;
					end else begin
						if (rel.gt) begin
							lo_q <= mid_q + AW'(1);
						end else begin
							hi_q <= mid_q - AW'(1);
						end
						state_q <= S_BS_RD;
					end
				end
				S_INS_RD: begin
					if (pos_q == '0) begin
						count_q    <= count_q + CW'(1);
						last_vld_q <= 1'b0;
						if (item_q.entry_radius > maxr_q) begin
							maxr_q <= item_q.entry_radius;
						end
						res_q   <= hit_res(new_entry, pos_q);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (rel.lt) begin
						pos_q   <= pos_q - AW'(1);
						state_q <= S_INS_RD;
					end else begin
						count_q    <= count_q + CW'(1);
						last_vld_q <= 1'b0;
						if (item_q.entry_radius > maxr_q) begin
							maxr_q <= item_q.entry_radius;
						end
						res_q   <= hit_res(new_entry, pos_q);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_EMIT;

	always_comb begin
		res                = res_q;
		res.largest_radius = maxr_q;
	end

endmodule

// ----- src/sorted_attribute_table_search_top.sv -----
// Top level of the sorted attribute table search block: ports, colour register, result register.
//
// This block keeps a table of object-type attributes sorted by 16-bit type key
// in a single-port-read RAM and serves one command per transaction: clear,
// insert or look up. It works on one transaction at a time and drops in_ready
// until the result has been handed to the result register, which lets the next
// transaction be accepted while a finished result still waits for out_ready.
// Every RAM read is an address state and then a compare state in the shared
// comparator, and that read loop sets the timing. A clear or a full-table
// insert goes from acceptance straight to the emit state. A lookup that hits
// the last-probed index passes through the cache read and compare states;
// otherwise each binary search probe is one read and one compare, after the
// cache read and compare when the last-probed index was tried first and
// missed. An insert does one read and compare for every entry with a larger
// key that has to move up one place, so building the table in ascending key
// order is fastest. The RAM contents are not cleared after reset; only
// entries below the fill count are ever used. The missing colour register
// may be written only while no transaction is in flight.
module sorted_attribute_table_search_top #(
	parameter int TABLE_DEPTH = sats_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] thing_type,
	input  logic [7:0]  entry_flags,
	input  logic [14:0] entry_radius,
	input  logic [7:0]  entry_colour,
	input  logic [15:0] entry_scale,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  hit_index,
	output logic [7:0]  hit_flags,
	output logic [14:0] hit_radius,
	output logic [7:0]  hit_colour,
	output logic [15:0] hit_scale,
	output logic [14:0] largest_radius
);

	// Colour returned for a type that is not in the table.
	logic [7:0]        missing_colour_q;

	// Result register: it decouples the sequencer from the consumer.
	sats_pkg::result_t out_q;
	logic              out_valid_q;

	sats_pkg::item_t   item;
	sats_pkg::result_t res;
	logic              res_valid;
	logic              res_ready;

	always_comb begin
		item.command      = command;
		item.thing_type   = thing_type;
		item.entry_flags  = entry_flags;
		item.entry_radius = entry_radius;
		item.entry_colour = entry_colour;
		item.entry_scale  = entry_scale;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_colour_q <= sats_pkg::RESET_COLOUR;
		end else if (cfg_we) begin
			missing_colour_q <= cfg_wdata;
		end
	end

	// The sequencer may hand over a result whenever the register is empty or
	// is being emptied in this same cycle.
	assign res_ready = !out_valid_q || out_ready;

	sats_seq #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.item           (item),
		.missing_colour (missing_colour_q),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign hit_index      = out_q.hit_index;
	assign hit_flags      = out_q.hit_flags;
	assign hit_radius     = out_q.hit_radius;
	assign hit_colour     = out_q.hit_colour;
	assign hit_scale      = out_q.hit_scale;
	assign largest_radius = out_q.largest_radius;

endmodule

// ----- dv/sorted_attribute_table_search_top_tb.sv -----
// Self-checking testbench for the sorted attribute table search block.
`timescale 1ns / 1ps

module sorted_attribute_table_search_top_tb;

	// Command code 3 is unused by the block and must behave as a lookup.
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam int DEPTH        = sats_pkg::TABLE_DEPTH_DEF;
	localparam int ITEM_TARGET  = 1150;
	// Worst case per transaction is an insert that shifts every stored entry up
	// one place, plus the longest gap and stall; taken several times over.
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [15:0] thing_type;
	logic [7:0]  entry_flags;
	logic [14:0] entry_radius;
	logic [7:0]  entry_colour;
	logic [15:0] entry_scale;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [7:0]  hit_index;
	logic [7:0]  hit_flags;
	logic [14:0] hit_radius;
	logic [7:0]  hit_colour;
	logic [15:0] hit_scale;
	logic [14:0] largest_radius;

	sorted_attribute_table_search_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.thing_type     (thing_type),
		.entry_flags    (entry_flags),
		.entry_radius   (entry_radius),
		.entry_colour   (entry_colour),
		.entry_scale    (entry_scale),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.hit_index      (hit_index),
		.hit_flags      (hit_flags),
		.hit_radius     (hit_radius),
		.hit_colour     (hit_colour),
		.hit_scale      (hit_scale),
		.largest_radius (largest_radius)
	);

	// 10 ns clock, driven with blocking assignments so that every process woken
	// by the rising edge still sees the values from before the edge.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Mirror of the block's state, kept by the predictor.
	// ------------------------------------------------------------------
	sats_pkg::entry_t stored_entries [DEPTH];
	int               fill_count;
	int               probe_idx;
	bit               probe_valid;
	logic [14:0]      widest_radius;
	logic [7:0]       absent_colour;

	// Results still owed by the block, oldest first.
	sats_pkg::result_t owed_results[$];

	int          fault_count;
	int          items_sent;
	int          cycle_count;
	bit          send_idle;
	bit          sink_idle;

	// Works out the result of one accepted transaction and moves the mirrored
	// state on, exactly as the block must.
	function automatic sats_pkg::result_t predict_result(input sats_pkg::item_t it);
		sats_pkg::result_t r;
		int                pos;
		int                i;
		int                lo;
		int                hi;
		int                mid;
		int                guard;
		bit                hit;
		bit                done;
		sats_pkg::entry_t  e;

		// Fields start at miss defaults; hits overwrite them, clear and full the status.
		r.status     = sats_pkg::ST_MISS;
		r.hit_index  = 8'd0;
		r.hit_flags  = 8'd0;
		r.hit_radius = sats_pkg::BASE_RADIUS;
		r.hit_colour = absent_colour;
		r.hit_scale  = sats_pkg::UNIT_SCALE;
		hit          = 1'b0;
		done         = 1'b0;
		pos          = 0;

		case (it.command)
			sats_pkg::CMD_CLEAR: begin
				fill_count    = 0;
				probe_valid   = 1'b0;
				probe_idx     = 0;
				widest_radius = sats_pkg::BASE_RADIUS;
				r.status      = sats_pkg::ST_OK;
			end
			sats_pkg::CMD_INSERT: begin
				if (fill_count >= DEPTH) begin
					r.status = sats_pkg::ST_FULL;
				end else begin
					e.key    = it.thing_type;
					e.flags  = it.entry_flags;
					e.radius = it.entry_radius;
					e.colour = it.entry_colour;
					e.scale  = it.entry_scale;
					// Equal keys stay ahead of the new entry, so only strictly larger
					// keys move up.
					pos = fill_count;
					while (pos > 0 && stored_entries[pos - 1].key > e.key)
						pos--;
					for (i = fill_count; i > pos; i--)
						stored_entries[i] = stored_entries[i - 1];
					stored_entries[pos] = e;
					fill_count++;
					probe_valid = 1'b0;
					if (e.radius > widest_radius)
						widest_radius = e.radius;
					r.status     = sats_pkg::ST_OK;
					r.hit_index  = pos[7:0];
					r.hit_flags  = e.flags;
					r.hit_radius = e.radius;
					r.hit_colour = e.colour;
					r.hit_scale  = e.scale;
				end
			end
			default: begin
				// Lookup, and the spare code too. The last probed position is tried
				// first; it needs an exact key match to count as a hit.
				if (probe_valid && probe_idx < fill_count &&
						stored_entries[probe_idx].key == it.thing_type) begin
					hit = 1'b1;
					pos = probe_idx;
				end else if (fill_count != 0) begin
					lo = 0;
					hi = fill_count - 1;
					for (guard = 0; guard < 64 && !done; guard++) begin
						mid = (lo + hi) / 2;
						if (mid >= fill_count) begin
							done = 1'b1;
						end else begin
							// The cache follows every probe, even one that misses.
							probe_idx   = mid;
							probe_valid = 1'b1;
							if (it.thing_type > stored_entries[mid].key) begin
								if (lo >= hi)
									done = 1'b1;
								else
									lo = mid + 1;
							end else if (it.thing_type < stored_entries[mid].key) begin
								if (lo >= hi || mid < 1)
									done = 1'b1;
								else
									hi = mid - 1;
							end else begin
								hit  = 1'b1;
								pos  = mid;
								done = 1'b1;
							end
						end
					end
				end
				if (hit && pos < fill_count) begin
					r.status     = sats_pkg::ST_OK;
					r.hit_index  = pos[7:0];
					r.hit_flags  = stored_entries[pos].flags;
					r.hit_radius = stored_entries[pos].radius;
					r.hit_colour = stored_entries[pos].colour;
					r.hit_scale  = stored_entries[pos].scale;
				end
			end
		endcase
		r.largest_radius = widest_radius;
		return r;
	endfunction

	// Builds a transaction with random attributes. A quarter of the radii are
	// kept small so that the largest radius often stays at its floor of 16.
	function automatic sats_pkg::item_t make_item(input logic [1:0] cmd,
			input logic [15:0] key);
		sats_pkg::item_t it;
		it.command      = cmd;
		it.thing_type   = key;
		it.entry_flags  = 8'($urandom);
		it.entry_radius = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 31))
			: 15'($urandom);
		it.entry_colour = 8'($urandom);
		it.entry_scale  = 16'($urandom);
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Driving side.
	// ------------------------------------------------------------------

	// Presents one transaction and returns at the edge where it is accepted.
	// in_valid is left high so that a following transaction can follow on
	// directly; anything that waits lowers it first, wait_drained through release_input.
	task automatic send_item(input sats_pkg::item_t it);
		int gap;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= it.command;
		thing_type   <= it.thing_type;
		entry_flags  <= it.entry_flags;
		entry_radius <= it.entry_radius;
		entry_colour <= it.entry_colour;
		entry_scale  <= it.entry_scale;
		do
			@(posedge clk);
		while (!in_ready);
		owed_results.push_back(predict_result(it));
		items_sent++;
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	// Holds the sender back until every owed result has come out.
	task automatic wait_drained();
		release_input();
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// The colour register is only written with nothing in flight. Every
	// transaction produces a result, so an empty queue means the block is idle.
	task automatic write_missing_colour(input logic [7:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we        <= 1'b0;
		absent_colour  = value;
	endtask

	// ------------------------------------------------------------------
	// Receiving side: random stalls on out_ready.
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_idle && stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 15);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin
		sats_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing expected, status %0d index %0d", $time,
					status, hit_index);
				fault_count++;
			end else begin
				want = owed_results.pop_front();
				check_field("status", int'(want.status), int'(status));
				check_field("hit_index", int'(want.hit_index), int'(hit_index));
				check_field("hit_flags", int'(want.hit_flags), int'(hit_flags));
				check_field("hit_radius", int'(want.hit_radius), int'(hit_radius));
				check_field("hit_colour", int'(want.hit_colour), int'(hit_colour));
				check_field("hit_scale", int'(want.hit_scale), int'(hit_scale));
				check_field("largest_radius", int'(want.largest_radius),
					int'(largest_radius));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sorted_attribute_table_search_top: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Straight after reset the table is empty, so a lookup must miss with the
	// reset colour, and the spare command code must behave as a lookup.
	task automatic test_empty_lookup();
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'h0000));
		send_item(make_item(CMD_SPARE, 16'hFFFF));
		send_item(make_item(sats_pkg::CMD_CLEAR, 16'($urandom)));
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'h1234));
	endtask

	// Extreme keys and attribute values, a duplicate key, a middle insert, hits
	// at both ends, a miss, a repeated lookup served from the cache, and a miss
	// right after a cached position.
	task automatic test_edge_entries();
		sats_pkg::item_t it;
		it = make_item(sats_pkg::CMD_INSERT, 16'h0000);
		it.entry_flags  = 8'hFF;
		it.entry_radius = 15'h7FFF;
		it.entry_colour = 8'h00;
		it.entry_scale  = 16'hFFFF;
		send_item(it);
		it = make_item(sats_pkg::CMD_INSERT, 16'hFFFF);
		it.entry_flags  = 8'h00;
		it.entry_radius = 15'h0000;
		it.entry_colour = 8'hFF;
		it.entry_scale  = 16'h0000;
		send_item(it);
		// An equal key goes after the one already there.
		send_item(make_item(sats_pkg::CMD_INSERT, 16'h0000));
		send_item(make_item(sats_pkg::CMD_INSERT, 16'd100));
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'h0000));
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'hFFFF));
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'd100));
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'd100));
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'd50));
		send_item(make_item(CMD_SPARE, 16'd100));
		// Clearing brings the largest radius back to its floor.
		send_item(make_item(sats_pkg::CMD_CLEAR, 16'h0000));
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'd100));
		it = make_item(sats_pkg::CMD_INSERT, 16'd7);
		it.entry_radius = 15'd3;
		send_item(it);
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'd7));
	endtask

	// Both extremes of the colour register and one value in between, each
	// seen through a miss.
	task automatic test_missing_colour();
		write_missing_colour(8'h00);
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'hBEEF));
		write_missing_colour(8'hFF);
		send_item(make_item(sats_pkg::CMD_LOOKUP, 16'hBEEF));
		write_missing_colour(8'($urandom_range(1, 254)));
		send_item(make_item(CMD_SPARE, 16'hBEEF));
	endtask

	// Fills the table to capacity. Keys ascend, with repeats, so no entry has to
	// move and the fill stays quick. Inserts into the full table must be refused
	// without changing anything, and the full-depth search must still find keys.
	task automatic test_full_table();
		logic [15:0] keys[$];
		int          key;
		int          i;
		send_item(make_item(sats_pkg::CMD_CLEAR, 16'h0000));
		key = 0;
		for (i = 0; i < DEPTH; i++) begin
			keys.push_back(key[15:0]);
			send_item(make_item(sats_pkg::CMD_INSERT, key[15:0]));
			key = key + $urandom_range(0, 255);
		end
		send_item(make_item(sats_pkg::CMD_INSERT, 16'($urandom)));
		send_item(make_item(sats_pkg::CMD_INSERT, 16'hFFFF));
		for (i = 0; i < 40; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_item(make_item(sats_pkg::CMD_LOOKUP, 16'($urandom)));
			else
				send_item(make_item(sats_pkg::CMD_LOOKUP,
					keys[$urandom_range(0, keys.size() - 1)]));
		end
		send_item(make_item(sats_pkg::CMD_LOOKUP, keys[0]));
		send_item(make_item(sats_pkg::CMD_LOOKUP, keys[DEPTH - 1]));
	endtask

	// One round: clear, build a small table from random keys, then mostly
	// lookups of stored keys, their neighbours and random keys, mixed with late
	// inserts, the spare code and the odd stray clear.
	task automatic run_round(input int n_build, input int n_query, input bit narrow);
		logic [15:0] keys[$];
		logic [15:0] key;
		int          base;
		int          sel;
		int          i;
		base = $urandom_range(0, 65535 - 63);
		send_item(make_item(sats_pkg::CMD_CLEAR, 16'($urandom)));
		for (i = 0; i < n_build; i++) begin
			key = narrow ? 16'(base + $urandom_range(0, 63)) : 16'($urandom);
			keys.push_back(key);
			send_item(make_item(sats_pkg::CMD_INSERT, key));
		end
		for (i = 0; i < n_query; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 2) begin
				keys.delete();
				send_item(make_item(sats_pkg::CMD_CLEAR, 16'($urandom)));
			end else if (sel < 10) begin
				key = narrow ? 16'(base + $urandom_range(0, 63)) : 16'($urandom);
				keys.push_back(key);
				send_item(make_item(sats_pkg::CMD_INSERT, key));
			end else begin
				if (sel < 70 && keys.size() != 0)
					key = keys[$urandom_range(0, keys.size() - 1)];
				else if (sel < 85 && keys.size() != 0)
					key = keys[$urandom_range(0, keys.size() - 1)] +
						(($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0001);
				else
					key = narrow ? 16'(base + $urandom_range(0, 63)) : 16'($urandom);
				send_item(make_item(($urandom_range(0, 9) == 0) ? CMD_SPARE
					: sats_pkg::CMD_LOOKUP, key));
			end
		end
	endtask

	// Random rounds, with idling on either side switched on and off per round so
	// that there are quiet stretches as well as busy ones.
	task automatic test_random_rounds(input int target);
		while (items_sent < target) begin
			send_idle = ($urandom_range(0, 2) != 0);
			sink_idle = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 3) == 0)
				write_missing_colour(8'($urandom));
			run_round($urandom_range(0, 40), $urandom_range(10, 40),
				$urandom_range(0, 1) == 1);
		end
	endtask

	// The last stretch runs with no idling on either side.
	task automatic test_quiet_tail();
		wait_drained();
		send_idle = 1'b0;
		sink_idle = 1'b0;
		run_round(20, 40, 1'b1);
	endtask

	initial begin
		fault_count   = 0;
		items_sent    = 0;
		cycle_count   = 0;
		send_idle     = 1'b1;
		sink_idle     = 1'b1;
		fill_count    = 0;
		probe_idx     = 0;
		probe_valid   = 1'b0;
		widest_radius = sats_pkg::BASE_RADIUS;
		absent_colour = sats_pkg::RESET_COLOUR;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= 8'h00;
		in_valid     <= 1'b0;
		command      <= sats_pkg::CMD_CLEAR;
		thing_type   <= 16'h0000;
		entry_flags  <= 8'h00;
		entry_radius <= 15'h0000;
		entry_colour <= 8'h00;
		entry_scale  <= 16'h0000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lookup();
		test_edge_entries();
		test_missing_colour();
		// The sender pauses here until the block has answered everything.
		wait_drained();
		test_full_table();
		test_random_rounds(ITEM_TARGET - 60);
		test_quiet_tail();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("sorted_attribute_table_search_top: match");
		else
			$display("sorted_attribute_table_search_top: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
src/sats_pkg.sv
src/sats_ram.sv
src/sats_cmp.sv
src/sats_seq.sv
src/sorted_attribute_table_search_top.sv
dv/sorted_attribute_table_search_top_tb.sv
